>>> rtl/assert_macros.svh
// Assertion macros shared by the reversible deque RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RDQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDQ_ASSERT(lbl, prop, msg)
`define RDQ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/rdq_pkg.sv
// Package for the reversible deque: sizes, operation and status codes,
// and the access struct passed from pointer control to the ring memory.
package rdq_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_REVERSE    = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd4;

  localparam logic [STAT_W-1:0] ST_DATA  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              emit;
    addr_t             addr;
    logic [STAT_W-1:0] status;
  } acc_t;

endpackage

>>> rtl/rdq_if.sv
// Valid/ready channel interfaces for the reversible deque.
// Depends on rdq_pkg.
interface rdq_in_if;
  logic                              valid;
  logic                              ready;
  logic [rdq_pkg::OP_W-1:0]          op;
  logic signed [rdq_pkg::DATA_W-1:0] value;
  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface rdq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rdq_pkg::DATA_W-1:0] value_res;
  logic [rdq_pkg::STAT_W-1:0]        status;
  modport source (output valid, value_res, status, input ready);
  modport sink   (input valid, value_res, status, output ready);
endinterface

>>> rtl/rdq_ptrs.sv
// End pointers, occupancy and orientation of the deque ring.
// Turns each accepted beat into at most one ring access. Depends on rdq_pkg.
`include "assert_macros.svh"
module rdq_ptrs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [rdq_pkg::OP_W-1:0] op,
  output rdq_pkg::acc_t            acc
);

  rdq_pkg::addr_t first_r, first_nxt;
  rdq_pkg::addr_t last_r, last_nxt;
  rdq_pkg::cnt_t  occ_r, occ_nxt;
  logic           rev_r, rev_nxt;
  logic           empty, full, rev_eff, at_head;

  function automatic rdq_pkg::addr_t inc(input rdq_pkg::addr_t i);
    return (i == rdq_pkg::ADDR_W'(rdq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic rdq_pkg::addr_t dec(input rdq_pkg::addr_t i);
    return (i == '0) ? rdq_pkg::ADDR_W'(rdq_pkg::DEPTH - 1) : i - 1'b1;
  endfunction

  assign empty = (occ_r == '0);
  assign full  = (occ_r == rdq_pkg::CNT_W'(rdq_pkg::DEPTH));

  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    occ_nxt   = occ_r;
    rev_nxt   = rev_r;
    rev_eff   = empty ? 1'b0 : rev_r;
    at_head   = 1'b0;
    acc       = '0;
    acc.status = rdq_pkg::ST_DATA;
    if (take) begin
      case (op)
        rdq_pkg::OP_REVERSE: begin
          rev_nxt = ~rev_r;
        end
        rdq_pkg::OP_PUSH_BACK, rdq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            acc.emit   = 1'b1;
            acc.status = rdq_pkg::ST_FULL;
          end else begin
            at_head   = (op == rdq_pkg::OP_PUSH_FRONT) ^ rev_eff;
            rev_nxt   = rev_eff;
            occ_nxt   = occ_r + 1'b1;
            acc.wr_en = 1'b1;
            if (at_head) begin
              first_nxt = dec(first_r);
              acc.addr  = dec(first_r);
            end else begin
              acc.addr  = last_r;
              last_nxt  = inc(last_r);
            end
          end
        end
        rdq_pkg::OP_POP_BACK, rdq_pkg::OP_POP_FRONT: begin
          acc.emit = 1'b1;
          if (empty) begin
            acc.status = rdq_pkg::ST_EMPTY;
          end else begin
            at_head   = (op == rdq_pkg::OP_POP_FRONT) ^ rev_r;
            occ_nxt   = occ_r - 1'b1;
            acc.rd_en = 1'b1;
            if (occ_r == rdq_pkg::CNT_W'(1)) rev_nxt = 1'b0;
            if (at_head) begin
              acc.addr  = first_r;
              first_nxt = inc(first_r);
            end else begin
              last_nxt  = dec(last_r);
              acc.addr  = dec(last_r);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      last_r  <= '0;
      occ_r   <= '0;
      rev_r   <= 1'b0;
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
      occ_r   <= occ_nxt;
      rev_r   <= rev_nxt;
    end
  end

  `RDQ_ASSERT(a_occ_range, occ_r <= rdq_pkg::CNT_W'(rdq_pkg::DEPTH), "occupancy above depth")
  `RDQ_ASSERT(a_ends_meet, (empty || full) |-> (first_r == last_r), "ends disagree with count")
  `RDQ_ASSERT(a_one_access, !(acc.wr_en && acc.rd_en), "read and write in one beat")
  `RDQ_ASSERT_RST(a_reset, !rst_n |=> (occ_r == '0 && !rev_r), "reset left state")

endmodule

>>> rtl/reversible_deque.sv
// Reversible deque: pops return the word in status 0, a pop on an empty queue returns status 1
// and a push into a full queue (DEPTH words) returns status 2; no other op gives a beat.
// One operation is accepted per cycle while the result path drains; a result moves from the
// ring read data and pending status registers into the output register; the ring memory is
// single-port. The ring needs no clearing pass after reset.
`include "assert_macros.svh"
module reversible_deque (
  input  logic     clk,
  input  logic     rst_n,
  rdq_in_if.sink   in_ch,
  rdq_out_if.source out_ch
);

  logic signed [rdq_pkg::DATA_W-1:0] mem [rdq_pkg::DEPTH];
  logic signed [rdq_pkg::DATA_W-1:0] rdata_r;
  logic signed [rdq_pkg::DATA_W-1:0] oval_r;
  logic [rdq_pkg::STAT_W-1:0]        pstat_r, ostat_r;
  logic                              pend_v_r, pend_v_nxt;
  logic                              out_v_r, out_v_nxt;
  logic                              out_free, take, move;
  rdq_pkg::acc_t                     acc;

  assign out_free    = !out_v_r || out_ch.ready;
  assign in_ch.ready = !pend_v_r || out_free;
  assign take        = in_ch.valid && in_ch.ready;
  assign move        = pend_v_r && out_free;

  rdq_ptrs u_ptrs (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .op    (in_ch.op),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (acc.wr_en) mem[acc.addr] <= in_ch.value;
    if (acc.rd_en) rdata_r <= mem[acc.addr];
  end

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (move) pend_v_nxt = 1'b0;
    if (take && acc.emit) pend_v_nxt = 1'b1;
    out_v_nxt = out_v_r;
    if (out_ch.ready) out_v_nxt = 1'b0;
    if (move) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && acc.emit) pstat_r <= acc.status;
    if (move) begin
      ostat_r <= pstat_r;
      oval_r  <= (pstat_r == rdq_pkg::ST_DATA) ? rdata_r : '0;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.value_res = oval_r;
  assign out_ch.status    = ostat_r;

  `RDQ_ASSERT(a_pend_hold, (pend_v_r && !out_free) |=> pend_v_r, "pending result lost")
  `RDQ_ASSERT(a_emit_lands, (take && acc.emit) |=> pend_v_r, "result not staged")
  `RDQ_ASSERT(a_no_clobber, (pend_v_r && !out_free) |-> !take, "beat taken over stuck result")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for reversible_deque: directed operation table, then random mixed and fill traffic.
// Results checked against a deque predictor or typed table rows. Depends on rdq_pkg and rdq_if.
module tb;

  localparam logic [rdq_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [rdq_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [rdq_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int MIX_ITEMS = 100;

  typedef struct packed {
    logic signed [rdq_pkg::DATA_W-1:0] value_res;
    logic [rdq_pkg::STAT_W-1:0]        status;
  } deque_res_t;

  typedef struct packed {
    logic [rdq_pkg::OP_W-1:0]   op;
    logic [rdq_pkg::DATA_W-1:0] value;
    bit                         typed;
    deque_res_t                 want;
  } dir_row_t;

  typedef enum int {MIX_OPS, FILL_OPS} traffic_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rdq_in_if  in_ch();
  rdq_out_if out_ch();

  reversible_deque dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // deque predictor
  logic [rdq_pkg::DATA_W-1:0] shadow_ring [rdq_pkg::DEPTH];
  int head_idx = 0;
  int tail_idx = 0;
  int word_cnt = 0;
  bit flipped = 1'b0;
  deque_res_t pending_res[$];

  int fails = 0;
  int results_seen = 0;
  int full_hits = 0;
  int send_burst = 0;
  int recv_burst = 0;

  dir_row_t steps [0:22] = '{
    '{rdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'sd0, rdq_pkg::ST_EMPTY}},
    '{rdq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{32'sd0, rdq_pkg::ST_EMPTY}},
    '{rdq_pkg::OP_REVERSE,    32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{OP_RSVD_5,              32'hFFFF_FFFF, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{OP_RSVD_6,              32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{OP_RSVD_7,              32'hA5A5_A5A5, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_REVERSE,    32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1, '{-32'sd1, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_PUSH_FRONT, 32'h1234_5678, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'sd0, rdq_pkg::ST_EMPTY}},
    '{rdq_pkg::OP_REVERSE,    32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_REVERSE,    32'h0000_0000, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, '{32'sd0, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'sh5A5A_5A5A, rdq_pkg::ST_DATA}},
    '{rdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'sd0, rdq_pkg::ST_EMPTY}}
  };

  function automatic int ring_up(int i);
    return (i + 1 >= rdq_pkg::DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int ring_down(int i);
    return (i == 0) ? rdq_pkg::DEPTH - 1 : i - 1;
  endfunction

  function automatic void deque_apply(input logic [rdq_pkg::OP_W-1:0] op,
                                      input logic [rdq_pkg::DATA_W-1:0] v,
                                      output bit emits, output deque_res_t r);
    bit at_head;
    emits = 1'b0;
    r = '0;
    case (op)
      rdq_pkg::OP_REVERSE: begin
        flipped = !flipped;
      end
      rdq_pkg::OP_PUSH_BACK, rdq_pkg::OP_PUSH_FRONT: begin
        if (word_cnt >= rdq_pkg::DEPTH) begin
          emits = 1'b1;
          r.status = rdq_pkg::ST_FULL;
        end else begin
          if (word_cnt == 0) flipped = 1'b0;
          at_head = (op == rdq_pkg::OP_PUSH_FRONT) ? !flipped : flipped;
          if (at_head) begin
            head_idx = ring_down(head_idx);
            shadow_ring[head_idx] = v;
          end else begin
            shadow_ring[tail_idx] = v;
            tail_idx = ring_up(tail_idx);
          end
          word_cnt++;
        end
      end
      rdq_pkg::OP_POP_BACK, rdq_pkg::OP_POP_FRONT: begin
        emits = 1'b1;
        if (word_cnt == 0) begin
          r.status = rdq_pkg::ST_EMPTY;
        end else begin
          at_head = (op == rdq_pkg::OP_POP_FRONT) ? !flipped : flipped;
          if (at_head) begin
            r.value_res = shadow_ring[head_idx];
            head_idx = ring_up(head_idx);
          end else begin
            tail_idx = ring_down(tail_idx);
            r.value_res = shadow_ring[tail_idx];
          end
          word_cnt--;
          if (word_cnt == 0) flipped = 1'b0;
          r.status = rdq_pkg::ST_DATA;
        end
      end
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long, with stretches of none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [rdq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rdq_pkg::OP_W-1:0] pick_op(traffic_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_OPS: begin
        if (r < 48) return rdq_pkg::OP_PUSH_BACK;
        if (r < 96) return rdq_pkg::OP_PUSH_FRONT;
        if (r < 97) return rdq_pkg::OP_POP_BACK;
        if (r < 98) return rdq_pkg::OP_POP_FRONT;
        if (r < 99) return rdq_pkg::OP_REVERSE;
        return OP_RSVD_6;
      end
      default: begin
        if (r < 20) return rdq_pkg::OP_POP_BACK;
        if (r < 40) return rdq_pkg::OP_POP_FRONT;
        if (r < 50) return rdq_pkg::OP_REVERSE;
        if (r < 73) return rdq_pkg::OP_PUSH_BACK;
        if (r < 96) return rdq_pkg::OP_PUSH_FRONT;
        if (r < 97) return OP_RSVD_5;
        if (r < 98) return OP_RSVD_6;
        return OP_RSVD_7;
      end
    endcase
  endfunction

  task automatic issue(input logic [rdq_pkg::OP_W-1:0] op, input logic [rdq_pkg::DATA_W-1:0] v,
                       input bit typed, input deque_res_t typed_res);
    int gap;
    bit emits;
    deque_res_t r;
    gap = pick_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op    = op;
    in_ch.value = v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    deque_apply(op, v, emits, r);
    if (emits) begin
      pending_res.insert(pending_res.size(), typed ? typed_res : r);
      if (r.status == rdq_pkg::ST_FULL) full_hits++;
    end
  endtask

  task automatic run_random(traffic_t mode, int count);
    for (int i = 0; i < count; i++) issue(pick_op(mode), pick_word(), 1'b0, '0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op    = rdq_pkg::OP_POP_BACK;
    in_ch.value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (steps[i]) issue(steps[i].op, steps[i].value, steps[i].typed, steps[i].want);

    run_random(MIX_OPS, MIX_ITEMS);
    full_hits = 0;
    while (full_hits < 8) issue(pick_op(FILL_OPS), pick_word(), 1'b0, '0);
    run_random(MIX_OPS, MIX_ITEMS);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result sink: random stalls plus one long hold-off to back up the queue
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 60) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall > 0) begin
        stall--;
        out_ch.ready = 1'b0;
      end else begin
        stall = ($urandom_range(0, 99) < 30) ? pick_gap(recv_burst) : 0;
        out_ch.ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin
    deque_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        $error("unexpected result beat: value_res %0d, status %0d",
               out_ch.value_res, out_ch.status);
        fails++;
      end else begin
        want = pending_res.pop_front();
        if (out_ch.value_res !== want.value_res) begin
          $error("value_res mismatch: expected %0d, got %0d", want.value_res, out_ch.value_res);
          fails++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_ch.status);
          fails++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $error("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
